@@ rtl/stq_pkg.sv @@
// ----------------------------------------------------------------------------
// stq_pkg
// Types, constants and helpers shared by the sorted timer queue modules.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int IDX_W      = $clog2(NUM_TIMERS);
  localparam int POS_W      = $clog2(NUM_TIMERS + 1);
  localparam int ID_W       = 4;
  localparam int DUR_W      = 31;
  localparam int TIME_W     = 32;
  localparam int MAX_POPS   = 16;
  localparam int POPS_W     = $clog2(MAX_POPS);

  localparam logic KIND_STATUS  = 1'b0;
  localparam logic KIND_EXPIRED = 1'b1;

  typedef enum logic [1:0] {
    CMD_ARM    = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [ID_W-1:0]   timer_id;
    logic [DUR_W-1:0]  duration;
  } req_t;

  typedef struct packed {
    logic              kind;
    logic [ID_W-1:0]   expired_id;
    logic              head_valid;
    logic [TIME_W-1:0] head_expiry;
    logic              last;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RM_SCAN,
    ST_RM_SHIFT,
    ST_INS_SCAN,
    ST_INS_SHIFT,
    ST_POP,
    ST_STATUS
  } state_t;

  typedef struct packed {
    logic load;
    logic pos_inc;
    logic remove;
    logic remove_head;
    logic insert;
    logic tick;
    logic emit_pop;
    logic emit_status;
  } ctrl_t;

  typedef struct packed {
    cmd_t cmd;
    logic queued;
    logic id_match;
    logic ins_stop;
    logic pop_due;
    logic pop_last;
    logic out_free;
  } stat_t;

  // a is before b when the wrapped difference is negative
  function automatic logic is_before(input logic [TIME_W-1:0] a,
                                     input logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] diff;
    diff = a - b;
    return diff[TIME_W-1];
  endfunction

endpackage

@@ rtl/sorted_timer_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_timer_queue
// Expiry-ordered queue of numbered timers with arm, cancel and tick items.
// ----------------------------------------------------------------------------
// Steps: an arm of a queued timer scans to remove and shifts, then every arm
//   scans to insert and shifts; a cancel of a queued timer scans and shifts.
//   Each ends in a status result; a tick gives one expiry result per expired
//   timer, else a status result. Throughput: one item at a time, the next taken
//   after its last result; scans walk the entry array one position per cycle.
// Reset clears time, count and queued flags; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_timer_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  stq_pkg::req_t  req_data,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output stq_pkg::rsp_t  rsp_data
);

  stq_pkg::ctrl_t ctrl;
  stq_pkg::stat_t stat;

  stq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  stq_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data),
    .ctrl      (ctrl),
    .stat      (stat)
  );

endmodule

@@ rtl/stq_ctrl.sv @@
// ----------------------------------------------------------------------------
// stq_ctrl
// Command sequencer: decodes an item and steps the datapath through
// removal scan, insertion scan and expiry pops.
// ----------------------------------------------------------------------------
module stq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  stq_pkg::stat_t  stat,
  output stq_pkg::ctrl_t  ctrl
);

  stq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      stq_pkg::ST_IDLE: begin
        if (req_valid) state_next = stq_pkg::ST_DECODE;
      end
      stq_pkg::ST_DECODE: begin
        unique case (stat.cmd)
          stq_pkg::CMD_ARM:    state_next = stat.queued ? stq_pkg::ST_RM_SCAN
                                                        : stq_pkg::ST_INS_SCAN;
          stq_pkg::CMD_CANCEL: state_next = stat.queued ? stq_pkg::ST_RM_SCAN
                                                        : stq_pkg::ST_STATUS;
          stq_pkg::CMD_TICK:   state_next = stq_pkg::ST_POP;
          default:             state_next = stq_pkg::ST_STATUS;
        endcase
      end
      stq_pkg::ST_RM_SCAN: begin
        if (stat.id_match) state_next = stq_pkg::ST_RM_SHIFT;
      end
      stq_pkg::ST_RM_SHIFT: begin
        state_next = (stat.cmd == stq_pkg::CMD_ARM) ? stq_pkg::ST_INS_SCAN
                                                    : stq_pkg::ST_STATUS;
      end
      stq_pkg::ST_INS_SCAN: begin
        if (stat.ins_stop) state_next = stq_pkg::ST_INS_SHIFT;
      end
      stq_pkg::ST_INS_SHIFT: begin
        state_next = stq_pkg::ST_STATUS;
      end
      stq_pkg::ST_POP: begin
        if (!stat.pop_due) begin
          state_next = stq_pkg::ST_STATUS;
        end else if (stat.out_free && stat.pop_last) begin
          state_next = stq_pkg::ST_IDLE;
        end
      end
      stq_pkg::ST_STATUS: begin
        if (stat.out_free) state_next = stq_pkg::ST_IDLE;
      end
      default: state_next = stq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl      = '0;
    req_ready = 1'b0;
    unique case (state)
      stq_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        ctrl.load = req_valid;
      end
      stq_pkg::ST_DECODE: begin
        ctrl.tick = (stat.cmd == stq_pkg::CMD_TICK);
      end
      stq_pkg::ST_RM_SCAN: begin
        ctrl.pos_inc = !stat.id_match;
      end
      stq_pkg::ST_RM_SHIFT: begin
        ctrl.remove = 1'b1;
      end
      stq_pkg::ST_INS_SCAN: begin
        ctrl.pos_inc = !stat.ins_stop;
      end
      stq_pkg::ST_INS_SHIFT: begin
        ctrl.insert = 1'b1;
      end
      stq_pkg::ST_POP: begin
        if (stat.pop_due && stat.out_free) begin
          ctrl.emit_pop    = 1'b1;
          ctrl.remove      = 1'b1;
          ctrl.remove_head = 1'b1;
        end
      end
      stq_pkg::ST_STATUS: begin
        ctrl.emit_status = stat.out_free;
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/stq_datapath.sv @@
// ----------------------------------------------------------------------------
// stq_datapath
// Ordered entry array, time counter, scan position and result register.
// ----------------------------------------------------------------------------
module stq_datapath (
  input  logic            clk,
  input  logic            rst,
  input  stq_pkg::req_t   req_data,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output stq_pkg::rsp_t   rsp_data,
  input  stq_pkg::ctrl_t  ctrl,
  output stq_pkg::stat_t  stat
);

  typedef struct packed {
    logic [stq_pkg::ID_W-1:0]   id;
    logic [stq_pkg::TIME_W-1:0] expiry;
  } entry_t;

  entry_t                          entries [stq_pkg::NUM_TIMERS];
  logic [stq_pkg::POS_W-1:0]       count;
  logic [stq_pkg::NUM_TIMERS-1:0]  flags;
  logic [stq_pkg::TIME_W-1:0]      cur_time;
  logic [stq_pkg::TIME_W-1:0]      deadline;
  logic [stq_pkg::POS_W-1:0]       pos;
  logic [stq_pkg::POPS_W-1:0]      pop_cnt;
  stq_pkg::cmd_t                   cur_cmd;
  logic [stq_pkg::ID_W-1:0]        cur_id;
  logic [stq_pkg::TIME_W-1:0]      new_exp;

  entry_t                          sel;
  logic [stq_pkg::IDX_W-1:0]       rm_pos;
  logic [stq_pkg::ID_W-1:0]        rm_id;
  logic                            more_left;

  assign sel       = entries[pos[stq_pkg::IDX_W-1:0]];
  assign rm_pos    = ctrl.remove_head ? '0 : pos[stq_pkg::IDX_W-1:0];
  assign rm_id     = ctrl.remove_head ? entries[0].id : cur_id;
  assign more_left = (count > stq_pkg::POS_W'(1));

  always_comb begin
    stat.cmd      = cur_cmd;
    stat.queued   = flags[cur_id];
    stat.id_match = (sel.id == cur_id);
    stat.ins_stop = (pos == count) || stq_pkg::is_before(new_exp, sel.expiry);
    stat.pop_due  = (count != '0) && stq_pkg::is_before(entries[0].expiry, deadline);
    stat.pop_last = (pop_cnt == stq_pkg::POPS_W'(stq_pkg::MAX_POPS - 1)) || !more_left ||
                    !stq_pkg::is_before(entries[1].expiry, deadline);
    stat.out_free = !rsp_valid || rsp_ready;
  end

  // queue entries
  always_ff @(posedge clk) begin
    for (int j = 0; j < stq_pkg::NUM_TIMERS; j++) begin
      if (ctrl.remove) begin
        if (j < stq_pkg::NUM_TIMERS - 1 && stq_pkg::IDX_W'(j) >= rm_pos) begin
          entries[j] <= entries[(j + 1) % stq_pkg::NUM_TIMERS];
        end
      end else if (ctrl.insert && count < stq_pkg::POS_W'(stq_pkg::NUM_TIMERS)) begin
        if (stq_pkg::POS_W'(j) > pos) begin
          entries[j] <= entries[(j + stq_pkg::NUM_TIMERS - 1) % stq_pkg::NUM_TIMERS];
        end else if (stq_pkg::POS_W'(j) == pos) begin
          entries[j] <= '{id: cur_id, expiry: new_exp};
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      flags    <= '0;
      cur_time <= '0;
      pos      <= '0;
      pop_cnt  <= '0;
    end else begin
      if (ctrl.load) begin
        pos <= '0;
      end else if (ctrl.pos_inc) begin
        pos <= pos + stq_pkg::POS_W'(1);
      end
      if (ctrl.remove) begin
        count        <= count - stq_pkg::POS_W'(1);
        flags[rm_id] <= 1'b0;
        pos          <= '0;
      end else if (ctrl.insert && count < stq_pkg::POS_W'(stq_pkg::NUM_TIMERS)) begin
        count         <= count + stq_pkg::POS_W'(1);
        flags[cur_id] <= 1'b1;
      end
      if (ctrl.tick) begin
        cur_time <= cur_time + stq_pkg::TIME_W'(1);
        pop_cnt  <= '0;
      end else if (ctrl.emit_pop) begin
        pop_cnt <= pop_cnt + stq_pkg::POPS_W'(1);
      end
    end
  end

  // item fields and deadline
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cur_cmd <= req_data.cmd;
      cur_id  <= req_data.timer_id;
      new_exp <= cur_time + {1'b0, req_data.duration};
    end
    if (ctrl.tick) begin
      deadline <= cur_time + stq_pkg::TIME_W'(2);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctrl.emit_pop || ctrl.emit_status) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit_pop) begin
      rsp_data.kind        <= stq_pkg::KIND_EXPIRED;
      rsp_data.expired_id  <= entries[0].id;
      rsp_data.head_valid  <= more_left;
      rsp_data.head_expiry <= more_left ? entries[1].expiry : '0;
      rsp_data.last        <= stat.pop_last;
    end else if (ctrl.emit_status) begin
      rsp_data.kind        <= stq_pkg::KIND_STATUS;
      rsp_data.expired_id  <= '0;
      rsp_data.head_valid  <= (count != '0);
      rsp_data.head_expiry <= (count != '0) ? entries[0].expiry : '0;
      rsp_data.last        <= 1'b1;
    end
  end

endmodule

@@ tb/sv/tb_sorted_timer_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_timer_queue
// Drives arm, cancel and tick items into the timer queue with random gaps on
// both handshakes, predicts every result from a behavioral copy of the
// expiry-ordered queue, and checks each result field by field in order.
// ----------------------------------------------------------------------------
module tb_sorted_timer_queue;

  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AT_ITEM = 120;
  localparam int TARGET_ITEMS = 280;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_ready;
  stq_pkg::req_t  req_data = '0;
  logic           rsp_valid;
  logic           rsp_ready = 1'b0;
  stq_pkg::rsp_t  rsp_data;

  sorted_timer_queue dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data (req_data),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_data (rsp_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // behavioral copy of the queue
  logic [stq_pkg::TIME_W-1:0] now_time;
  logic [stq_pkg::TIME_W-1:0] exp_at [stq_pkg::NUM_TIMERS];
  int                         q_order [stq_pkg::NUM_TIMERS];
  int                         q_len;
  bit                         is_queued [stq_pkg::NUM_TIMERS];

  stq_pkg::req_t cmd_q [$];
  stq_pkg::rsp_t timer_events_q [$];
  int   n_items;
  int   in_acc = 0;
  logic req_took = 1'b0;
  int   errors = 0;
  int   idle_cycles = 0;

  function automatic bit precedes(logic [stq_pkg::TIME_W-1:0] a,
                                  logic [stq_pkg::TIME_W-1:0] b);
    logic [stq_pkg::TIME_W-1:0] d;
    d = a - b;
    return d[stq_pkg::TIME_W-1];
  endfunction

  function void unlink_timer(int id);
    int i;
    int j;
    if (!is_queued[id]) return;
    for (i = 0; i < q_len; i++) begin
      if (q_order[i] == id) begin
        for (j = i; j + 1 < q_len; j++) q_order[j] = q_order[j+1];
        q_len--;
        break;
      end
    end
    is_queued[id] = 1'b0;
  endfunction

  function void link_timer(int id);
    int pos;
    int j;
    pos = 0;
    if (q_len >= stq_pkg::NUM_TIMERS) return;
    while (pos < q_len && !precedes(exp_at[id], exp_at[q_order[pos]])) pos++;
    for (j = q_len; j > pos; j--) q_order[j] = q_order[j-1];
    q_order[pos] = id;
    q_len++;
    is_queued[id] = 1'b1;
  endfunction

  function stq_pkg::rsp_t head_report(logic kind, int id, logic fin);
    stq_pkg::rsp_t r;
    r.kind        = kind;
    r.expired_id  = stq_pkg::ID_W'(id);
    r.head_valid  = (q_len > 0);
    r.head_expiry = (q_len > 0) ? exp_at[q_order[0]] : '0;
    r.last        = fin;
    return r;
  endfunction

  function void apply_timer_cmd(stq_pkg::req_t r);
    int            id;
    int            n;
    int            hd;
    stq_pkg::rsp_t held;
    id = int'(r.timer_id);
    n = 0;
    case (r.cmd)
      stq_pkg::CMD_ARM: begin
        if (id < stq_pkg::NUM_TIMERS) begin
          unlink_timer(id);
          exp_at[id] = now_time + stq_pkg::TIME_W'(r.duration);
          link_timer(id);
        end
      end
      stq_pkg::CMD_CANCEL: begin
        if (id < stq_pkg::NUM_TIMERS) unlink_timer(id);
      end
      stq_pkg::CMD_TICK: begin
        now_time++;
        while (n < stq_pkg::MAX_POPS && q_len > 0) begin
          hd = q_order[0];
          if (!precedes(exp_at[hd], now_time + 1)) break;
          unlink_timer(hd);
          if (n > 0) timer_events_q.push_back(held);
          held = head_report(stq_pkg::KIND_EXPIRED, hd, 1'b0);
          n++;
        end
        if (n > 0) begin
          held.last = 1'b1;
          timer_events_q.push_back(held);
        end
      end
      default: ;
    endcase
    if (n == 0) timer_events_q.push_back(head_report(stq_pkg::KIND_STATUS, 0, 1'b1));
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic push_cmd(stq_pkg::cmd_t c, int id, logic [stq_pkg::DUR_W-1:0] d);
    stq_pkg::req_t r;
    r.cmd      = c;
    r.timer_id = stq_pkg::ID_W'(id);
    r.duration = d;
    cmd_q.push_back(r);
    if (c != stq_pkg::CMD_NOP) n_items++;
  endtask

  task automatic report(string name, longint unsigned e, longint unsigned a);
    errors++;
    $display("%0t: mismatch %s expected %0h actual %0h", $time, name, e, a);
  endtask

  // sender
  int send_gap = 0;
  int send_calm = 0;
  always @(negedge clk) begin
    if (!rst && (!req_valid || req_took)) begin
      if (send_calm > 0) send_calm--;
      else if ($urandom_range(0, 99) < 3) send_calm = $urandom_range(20, 60);
      if (send_gap > 0) begin
        send_gap--;
        req_valid <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        req_data  <= cmd_q.pop_front();
        req_valid <= 1'b1;
        send_gap = (send_calm > 0) ? 0 : pick_gap();
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // receiver
  int  recv_gap = 0;
  int  recv_calm = 0;
  int  hold_left = 0;
  bit  held_off = 1'b0;
  always @(negedge clk) begin
    if (!rst) begin
      if (!held_off && in_acc >= HOLD_AT_ITEM) begin
        held_off = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (recv_calm > 0) recv_calm--;
      else if ($urandom_range(0, 99) < 3) recv_calm = $urandom_range(20, 60);
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
        recv_gap = (recv_calm > 0) ? 0 : pick_gap();
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    stq_pkg::rsp_t e;
    req_took <= req_valid && req_ready;
    if (!rst) begin
      if (req_valid && req_ready) begin
        apply_timer_cmd(req_data);
        in_acc <= in_acc + 1;
      end
      if (rsp_valid && rsp_ready) begin
        if (timer_events_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result expected none actual %0h", $time, rsp_data);
        end else begin
          e = timer_events_q.pop_front();
          if (e.kind != rsp_data.kind) report("kind", e.kind, rsp_data.kind);
          if (e.expired_id != rsp_data.expired_id)
            report("expired_id", e.expired_id, rsp_data.expired_id);
          if (e.head_valid != rsp_data.head_valid)
            report("head_valid", e.head_valid, rsp_data.head_valid);
          if (e.head_expiry != rsp_data.head_expiry)
            report("head_expiry", e.head_expiry, rsp_data.head_expiry);
          if (e.last != rsp_data.last) report("last", e.last, rsp_data.last);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int k;
    int sel;
    int cnt;
    int base;
    logic [stq_pkg::DUR_W-1:0] d;
    rst = 1'b1;
    now_time = '0;
    q_len = 0;
    n_items = 0;
    for (k = 0; k < stq_pkg::NUM_TIMERS; k++) begin
      is_queued[k] = 1'b0;
      exp_at[k] = '0;
      q_order[k] = 0;
    end

    // directed: empty tick, idle cancel, unused command, extremes, re-arm,
    // equal expiries, cancel of a queued timer, then many expiries on one tick
    push_cmd(stq_pkg::CMD_TICK, 0, '0);
    push_cmd(stq_pkg::CMD_CANCEL, 5, '0);
    push_cmd(stq_pkg::CMD_NOP, 15, '1);
    push_cmd(stq_pkg::CMD_ARM, 15, '1);
    push_cmd(stq_pkg::CMD_ARM, 3, '0);
    push_cmd(stq_pkg::CMD_ARM, 4, '0);
    push_cmd(stq_pkg::CMD_ARM, 3, stq_pkg::DUR_W'(1));
    push_cmd(stq_pkg::CMD_CANCEL, 15, '0);
    push_cmd(stq_pkg::CMD_TICK, 0, '0);
    push_cmd(stq_pkg::CMD_TICK, 0, '0);
    for (k = 0; k < 14; k++) push_cmd(stq_pkg::CMD_ARM, k, '0);
    push_cmd(stq_pkg::CMD_TICK, 0, '0);

    while (n_items < TARGET_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        cnt = $urandom_range(1, 6);
        for (k = 0; k < cnt; k++) begin
          if ($urandom_range(0, 99) < 15) d = stq_pkg::DUR_W'($urandom);
          else d = stq_pkg::DUR_W'($urandom_range(0, 4));
          push_cmd(stq_pkg::CMD_ARM, $urandom_range(0, 15), d);
          if ($urandom_range(0, 99) < 20)
            push_cmd(stq_pkg::CMD_CANCEL, $urandom_range(0, 15), '0);
        end
        cnt = $urandom_range(1, 5);
        for (k = 0; k < cnt; k++)
          push_cmd(stq_pkg::CMD_TICK, 0, stq_pkg::DUR_W'($urandom));
      end else if (sel < 62) begin
        base = $urandom_range(0, 15);
        for (k = 0; k < stq_pkg::NUM_TIMERS; k++)
          push_cmd(stq_pkg::CMD_ARM, (base + k) % stq_pkg::NUM_TIMERS,
                   stq_pkg::DUR_W'($urandom_range(0, 2)));
        for (k = 0; k < 3; k++) push_cmd(stq_pkg::CMD_TICK, $urandom_range(0, 15), '0);
      end else if (sel < 72) begin
        push_cmd(stq_pkg::CMD_CANCEL, $urandom_range(0, 15), stq_pkg::DUR_W'($urandom));
      end else begin
        d = ($urandom_range(0, 1) == 1) ? stq_pkg::DUR_W'($urandom)
                                        : stq_pkg::DUR_W'($urandom_range(0, 3));
        push_cmd(stq_pkg::cmd_t'($urandom_range(0, 3)), $urandom_range(0, 15), d);
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (cmd_q.size() > 0 || req_valid || timer_events_q.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/stq_pkg.sv
rtl/stq_ctrl.sv
rtl/stq_datapath.sv
rtl/sorted_timer_queue.sv
tb/sv/tb_sorted_timer_queue.sv
